// File: sv/stfs_pkg.sv
package stfs_pkg;

	localparam int SLOTS      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);

	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [1:0] {
		KIND_ADD  = 2'd0,
		KIND_FREE = 2'd1,
		KIND_GET  = 2'd2,
		KIND_SIZE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	typedef struct packed {
		logic  vacant;
		data_t data;
	} entry_t;

	typedef struct packed {
		logic   we;
		slot_t  addr;
		entry_t entry;
	} slot_wr_t;

	typedef struct packed {
		logic  push;
		logic  pop;
		slot_t push_slot;
	} stack_ctl_t;

endpackage

// File: sv/stfs_slot_mem.sv
module stfs_slot_mem
	import stfs_pkg::*;
(
	input  logic     clk,
	input  logic     rd_en,
	input  slot_t    rd_addr,
	output entry_t   rd_entry,
	input  slot_wr_t wr
);

	entry_t mem [SLOTS];
	entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule

// File: sv/stfs_free_stack.sv
module stfs_free_stack
	import stfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rd_en,
	input  stack_ctl_t ctl,
	output slot_t      top,
	output cnt_t       depth
);

	slot_t mem [SLOTS];
	slot_t top_q;
	cnt_t  depth_q;
	cnt_t  top_pos;

	assign top_pos = depth_q - cnt_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ctl.push) begin
			depth_q <= depth_q + cnt_t'(1);
		end else if (ctl.pop) begin
			depth_q <= depth_q - cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[depth_q[SLOT_W-1:0]] <= ctl.push_slot;
		end
		if (rd_en) begin
			top_q <= mem[top_pos[SLOT_W-1:0]];
		end
	end

	assign top   = top_q;
	assign depth = depth_q;

endmodule

// File: sv/slot_table_with_free_stack_unit.sv
// Slot table with a stack of freed slots.
// An input beat carries kind, value and slot_index on a valid/ready channel. An add stores
// value in the most recently freed slot, or appends a new slot when none is free, and
// returns the slot used. A free marks a slot vacant and pushes its index. A get returns the
// slot's data or reports it vacant. A size query returns the number of appended slots.
// Full table, index beyond the count and double free are refused with a status code.
// Each accepted beat yields exactly one result beat on the output valid/ready channel.
// The block handles one item at a time: the slot memory and the stack memory are read when
// an item is accepted; the item is then held until the output register is free, and is
// resolved, written back and loaded into the output register. A new item is taken only
// once the current one has been loaded into the output register.
// When the receiver stalls, the result waits in the output register and the next item may
// already be accepted and read; it completes only once the output register is free.
// Reset clears the counts and the valid flags; the memories keep undefined contents, and
// only reads below the append count or the stack depth are used.
module slot_table_with_free_stack_unit
	import stfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic [31:0]           value,
	input  logic [7:0]            slot_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            result_slot,
	output logic [31:0]           result_data,
	output logic                  is_vacant,
	output logic [8:0]            slot_count,
	output logic [1:0]            status
);

	logic       accept;
	logic       commit;
	logic       s1_valid_q;
	kind_t      kind_s1;
	data_t      value_s1;
	slot_t      idx_s1;
	cnt_t       count_q;
	cnt_t       count_d;
	entry_t     rd_entry;
	slot_t      stack_top;
	cnt_t       stack_depth;
	slot_wr_t   slot_wr;
	stack_ctl_t stack_ctl;
	logic       in_range;
	slot_t      r_slot;
	data_t      r_data;
	logic       r_vac;
	status_t    r_status;
	logic       out_valid_q;
	slot_t      result_slot_q;
	data_t      result_data_q;
	logic       is_vacant_q;
	cnt_t       slot_count_q;
	status_t    status_q;

	assign in_ready = !s1_valid_q;
	assign accept   = in_valid && in_ready;
	assign commit   = s1_valid_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_t'(kind);
			value_s1 <= value[DATA_WIDTH-1:0];
			idx_s1   <= slot_index[SLOT_W-1:0];
		end
	end

	stfs_slot_mem u_slot_mem (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (slot_index[SLOT_W-1:0]),
		.rd_entry (rd_entry),
		.wr       (slot_wr)
	);

	stfs_free_stack u_free_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.ctl    (stack_ctl),
		.top    (stack_top),
		.depth  (stack_depth)
	);

	assign in_range = {1'b0, idx_s1} < count_q;

	always_comb begin
		r_slot              = '0;
		r_data              = '0;
		r_vac               = 1'b0;
		r_status            = ST_OK;
		count_d             = count_q;
		slot_wr.we          = 1'b0;
		slot_wr.addr        = idx_s1;
		slot_wr.entry       = '{vacant: 1'b0, data: value_s1};
		stack_ctl.push      = 1'b0;
		stack_ctl.pop       = 1'b0;
		stack_ctl.push_slot = idx_s1;
		case (kind_s1)
			KIND_ADD: begin
				if (stack_depth != '0) begin
					r_slot        = stack_top;
					slot_wr.we    = commit;
					slot_wr.addr  = stack_top;
					stack_ctl.pop = commit;
				end else if (count_q < cnt_t'(SLOTS)) begin
					r_slot       = count_q[SLOT_W-1:0];
					slot_wr.we   = commit;
					slot_wr.addr = count_q[SLOT_W-1:0];
					count_d      = count_q + cnt_t'(1);
				end else begin
					r_status = ST_FULL;
				end
			end
			KIND_FREE: begin
				r_slot = idx_s1;
				if (!in_range) begin
					r_status = ST_RANGE;
				end else if (rd_entry.vacant) begin
					r_status = ST_DOUBLE;
				end else begin
					slot_wr.we     = commit;
					slot_wr.entry  = '{vacant: 1'b1, data: rd_entry.data};
					stack_ctl.push = commit;
				end
			end
			KIND_GET: begin
				r_slot = idx_s1;
				if (!in_range) begin
					r_status = ST_RANGE;
				end else if (rd_entry.vacant) begin
					r_vac = 1'b1;
				end else begin
					r_data = rd_entry.data;
				end
			end
			default: begin
				r_slot = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_slot_q <= r_slot;
			result_data_q <= r_data;
			is_vacant_q   <= r_vac;
			slot_count_q  <= count_d;
			status_q      <= r_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_slot = 8'(result_slot_q);
	assign result_data = 32'(result_data_q);
	assign is_vacant   = is_vacant_q;
	assign slot_count  = 9'(slot_count_q);
	assign status      = status_q;

endmodule

// File: sv/stfs_checker.sv
module stfs_checker
	import stfs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  result_slot,
	input logic [31:0] result_data,
	input logic        is_vacant,
	input logic [8:0]  slot_count,
	input logic [1:0]  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_slot) && $stable(status))
		else $error("Stalled result beat changed or dropped.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |->
			slot_count == 9'(SLOTS) && result_slot == 8'd0 && result_data == 32'd0)
		else $error("Full status without a full table.");

	a_vacant_get: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_vacant |-> status == ST_OK && result_data == 32'd0)
		else $error("Vacant result carries data or an error status.");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid |-> slot_count >= $past(slot_count))
		else $error("Append count decreased between result beats.");

endmodule

bind slot_table_with_free_stack_unit stfs_checker u_stfs_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import stfs_pkg::*;

	localparam int IDLE_PCT    = 38;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int QUEUE_ROOM  = 3;

	typedef struct packed {
		kind_t k;
		data_t v;
		slot_t idx;
	} slot_op_t;

	typedef struct packed {
		slot_t   slot;
		data_t   data;
		logic    vac;
		cnt_t    count;
		status_t st;
	} slot_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	kind_t       kind = KIND_SIZE;
	logic [31:0] value = '0;
	logic [7:0]  slot_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  result_slot;
	logic [31:0] result_data;
	logic        is_vacant;
	logic [8:0]  slot_count;
	logic [1:0]  status;

	// Mirror of the slot table, advanced once per accepted input beat.
	data_t table_data [SLOTS];
	logic  table_vac  [SLOTS];
	slot_t free_lifo  [SLOTS];
	cnt_t  free_top = '0;
	cnt_t  appended = '0;

	slot_op_t    ops_waiting [$];
	slot_reply_t replies_due [$];

	int ops_queued = 0;
	int ops_taken = 0;
	int replies_seen = 0;
	int mismatches = 0;
	int vacant_hits = 0;
	int kind_hits [4] = '{0, 0, 0, 0};
	int status_hits [4] = '{0, 0, 0, 0};
	int cyc = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	logic in_beat = 1'b0;
	logic calm;

	assign calm = (cyc >= 1200) && (cyc < 1800);

	slot_table_with_free_stack_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.value      (value),
		.slot_index (slot_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_slot(result_slot),
		.result_data(result_data),
		.is_vacant  (is_vacant),
		.slot_count (slot_count),
		.status     (status)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic slot_reply_t apply_op(kind_t k, data_t v, slot_t idx);
		slot_reply_t r;
		slot_t       s;
		r = '0;
		r.st = ST_OK;
		case (k)
			KIND_ADD: begin
				if (free_top != 0) begin
					s = free_lifo[slot_t'(free_top - cnt_t'(1))];
					free_top = free_top - cnt_t'(1);
					table_data[s] = v;
					table_vac[s] = 1'b0;
					r.slot = s;
				end else if (appended < SLOTS) begin
					s = appended[SLOT_W-1:0];
					table_data[s] = v;
					table_vac[s] = 1'b0;
					appended = appended + cnt_t'(1);
					r.slot = s;
				end else begin
					r.st = ST_FULL;
				end
			end
			KIND_FREE: begin
				r.slot = idx;
				if (idx >= appended) begin
					r.st = ST_RANGE;
				end else if (table_vac[idx]) begin
					r.st = ST_DOUBLE;
				end else begin
					table_vac[idx] = 1'b1;
					free_lifo[free_top[SLOT_W-1:0]] = idx;
					free_top = free_top + cnt_t'(1);
				end
			end
			KIND_GET: begin
				r.slot = idx;
				if (idx >= appended) begin
					r.st = ST_RANGE;
				end else if (table_vac[idx]) begin
					r.vac = 1'b1;
				end else begin
					r.data = table_data[idx];
				end
			end
			default: begin
			end
		endcase
		r.count = appended;
		return r;
	endfunction

	task automatic queue_op(input kind_t k, input data_t v, input slot_t idx);
		slot_op_t op;
		while (ops_waiting.size() >= QUEUE_ROOM) @(posedge clk);
		op.k = k;
		op.v = v;
		op.idx = idx;
		ops_waiting.push_back(op);
		ops_queued++;
	endtask

	task automatic queue_random(input int add_w, input int free_w, input int get_w);
		int    roll;
		kind_t k;
		slot_t idx;
		roll = $urandom_range(99);
		if (roll < add_w)
			k = KIND_ADD;
		else if (roll < add_w + free_w)
			k = KIND_FREE;
		else if (roll < add_w + free_w + get_w)
			k = KIND_GET;
		else
			k = KIND_SIZE;
		if (appended != 0 && $urandom_range(99) < 90)
			idx = slot_t'($urandom_range(appended - 1));
		else
			idx = slot_t'($urandom_range(255));
		queue_op(k, $urandom, idx);
	endtask

	task automatic wait_drained();
		while (ops_taken != ops_queued || replies_due.size() != 0) @(negedge clk);
	endtask

	// Adds enough to empty the free stack, then five more that hit a full table once every slot is appended.
	task automatic burst_to_full();
		int n;
		wait_drained();
		n = free_top + 5;
		repeat (n) queue_op(KIND_ADD, $urandom, slot_t'($urandom_range(255)));
	endtask

	always @(negedge clk) begin
		slot_op_t op;
		if (arst_n && (!in_valid || in_beat)) begin
			if (ops_waiting.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				op = ops_waiting.pop_front();
				in_valid <= 1'b1;
				kind <= op.k;
				value <= op.v;
				slot_index <= op.idx;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && replies_seen >= 300) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 1;
			in_beat <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				replies_due.push_back(apply_op(kind, value, slot_index));
				kind_hits[kind]++;
				ops_taken++;
			end
		end
	end

	always @(posedge clk) begin
		slot_reply_t got;
		slot_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			got.slot = result_slot;
			got.data = result_data;
			got.vac = is_vacant;
			got.count = slot_count;
			got.st = status_t'(status);
			replies_seen++;
			status_hits[status]++;
			if (is_vacant)
				vacant_hits++;
			if (replies_due.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result beat with nothing expected: slot %0d data %h",
						$realtime, result_slot, result_data);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (got !== want) begin
					if (mismatches < 10) begin
						$write("%0t: result %0d differs: expected slot %0d data %h vac %b ",
							$realtime, replies_seen, want.slot, want.data, want.vac);
						$write("count %0d status %0d, ", want.count, want.st);
						$display("got slot %0d data %h vac %b count %0d status %0d",
							result_slot, result_data, is_vacant, slot_count, status);
					end
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("No beat moved for %0d cycles.", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int grown;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty table, refused indexes, data extremes, double free, vacant read, LIFO reuse.
		queue_op(KIND_SIZE, 32'h0, 8'd0);
		queue_op(KIND_GET, 32'hFFFFFFFF, 8'd0);
		queue_op(KIND_FREE, 32'h0, 8'd0);
		queue_op(KIND_GET, 32'h0, 8'd255);
		queue_op(KIND_FREE, 32'hFFFFFFFF, 8'd255);
		queue_op(KIND_ADD, 32'h00000000, 8'd255);
		queue_op(KIND_ADD, 32'hFFFFFFFF, 8'd0);
		queue_op(KIND_ADD, 32'hA5A5A5A5, 8'd170);
		queue_op(KIND_GET, 32'h0, 8'd0);
		queue_op(KIND_GET, 32'h0, 8'd1);
		queue_op(KIND_GET, 32'h0, 8'd2);
		queue_op(KIND_GET, 32'h0, 8'd3);
		queue_op(KIND_FREE, 32'h0, 8'd1);
		queue_op(KIND_FREE, 32'h0, 8'd1);
		queue_op(KIND_GET, 32'h0, 8'd1);
		queue_op(KIND_FREE, 32'h0, 8'd0);
		queue_op(KIND_ADD, 32'h12345678, 8'd0);
		queue_op(KIND_ADD, 32'h87654321, 8'd0);
		queue_op(KIND_ADD, 32'h5A5A5A5A, 8'd0);
		queue_op(KIND_GET, 32'h0, 8'd3);
		queue_op(KIND_SIZE, 32'hFFFFFFFF, 8'd255);

		grown = 0;
		while (appended < SLOTS && grown < 450) begin
			queue_random(75, 8, 12);
			grown++;
		end

		wait_drained();
		burst_to_full();
		repeat (220) queue_random(35, 35, 22);
		burst_to_full();
		repeat (220) queue_random(35, 35, 22);

		wait_drained();
		repeat (20) @(posedge clk);
		if (replies_due.size() != 0)
			mismatches++;
		$display("Run covered %0d items (add %0d, free %0d, get %0d, size %0d), %0d result beats.",
			ops_taken, kind_hits[KIND_ADD], kind_hits[KIND_FREE], kind_hits[KIND_GET],
			kind_hits[KIND_SIZE], replies_seen);
		$display("Statuses: ok %0d, full %0d, beyond count %0d, double free %0d; vacant gets %0d.",
			status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_RANGE],
			status_hits[ST_DOUBLE], vacant_hits);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
